### src/acrb_pkg.sv
// Shared constants, codes and angle table for the arcball rotation core.
// No dependencies; acrb_lift, acrb_acos and the top-level core import this package.
`default_nettype none
package acrb_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int WIN_W          = 13;
  localparam logic [WIN_W-1:0] WIDTH_RST  = 13'd1024;
  localparam logic [WIN_W-1:0] HEIGHT_RST = 13'd768;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam int TAB_FRAC     = 40;
  localparam int CORDIC_STEPS = 32;
  localparam int ANG_W        = 44;
  localparam int XY_W         = 34;
  localparam int ROOT_FRAC    = 30;
  localparam int SQ_W         = 2 * ROOT_FRAC + 2;

  typedef logic signed [ANG_W-1:0] ang_t;

  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic ang_t atan_pow2(input int i);
    longint unsigned p;
    longint          sum;
    longint          term;
    p   = 64'd1 << (TAB_FRAC - i);
    sum = 0;
    for (int k = 0; k < 64; k++) begin
      if (p != 0) begin
        term = longint'(udiv64(p, 64'(2 * k + 1)));
        sum  = ((k & 1) != 0) ? sum - term : sum + term;
        p    = p >> (2 * i);
      end
    end
    return ANG_W'(sum);
  endfunction

  function automatic ang_t atan_third();
    longint unsigned p;
    longint          sum;
    longint          term;
    p   = (64'd1 << TAB_FRAC) / 3;
    sum = 0;
    for (int k = 0; k < 64; k++) begin
      if (p != 0) begin
        term = longint'(udiv64(p, 64'(2 * k + 1)));
        sum  = ((k & 1) != 0) ? sum - term : sum + term;
        p    = p / 9;
      end
    end
    return ANG_W'(sum);
  endfunction

  function automatic ang_t atan_entry(input int i);
    if (i == 0) begin
      return atan_pow2(1) + atan_third();
    end
    return atan_pow2(i);
  endfunction

  function automatic int lift_latency(input int c, input int f);
    return (c + f + 2) + 3 + (f + 2) + 1 + (f + 2) + 1;
  endfunction

  function automatic int acos_latency();
    return 1 + (SQ_W / 2) + 1 + CORDIC_STEPS + 1;
  endfunction

endpackage
`default_nettype wire

### src/acrb_dly.sv
// Fixed-depth delay line that keeps side data aligned with the pipelines.
// No dependencies.
`default_nettype none
module acrb_dly #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    tap_r[0] <= d;
    for (int k = 1; k < DEPTH; k++) begin
      tap_r[k] <= tap_r[k-1];
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule
`default_nettype wire

### src/acrb_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// No dependencies; the quotient must fit in QUO_W bits.
`default_nettype none
module acrb_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 13,
  parameter int QUO_W = 28
) (
  input  wire logic             clk,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [QUO_W-1:0] quo
);

  logic [NUM_W:0]     num_ext;
  logic [DEN_W-1:0]   rem_init;
  logic [DEN_W-1:0]   rem_r [QUO_W];
  logic [QUO_W-1:0]   qn_r  [QUO_W];
  logic [DEN_W-1:0]   den_r [QUO_W];

  assign num_ext  = {1'b0, num};
  assign rem_init = DEN_W'(num_ext >> QUO_W);

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] qn_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    if (k == 0) begin : g_first
      assign rem_in = rem_init;
      assign den_in = den;
      assign qn_in  = num_ext[QUO_W-1:0];
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign qn_in  = qn_r[k-1];
    end
    assign trial = {rem_in, qn_in[QUO_W-1]};
    assign diff  = trial - {1'b0, den_in};
    always_ff @(posedge clk) begin
      den_r[k] <= den_in;
      if (trial >= {1'b0, den_in}) begin
        rem_r[k] <= diff[DEN_W-1:0];
        qn_r[k]  <= {qn_in[QUO_W-2:0], 1'b1};
      end else begin
        rem_r[k] <= trial[DEN_W-1:0];
        qn_r[k]  <= {qn_in[QUO_W-2:0], 1'b0};
      end
    end
  end

  assign quo = qn_r[QUO_W-1];

endmodule
`default_nettype wire

### src/acrb_sqrt.sv
// Pipelined restoring square root, one root bit per stage, with remainder.
// No dependencies; VW must be even.
`default_nettype none
module acrb_sqrt #(
  parameter int VW = 32
) (
  input  wire logic              clk,
  input  wire logic [VW-1:0]     val,
  output logic      [VW/2-1:0]   root,
  output logic      [VW/2:0]     rem
);

  localparam int RW = VW / 2;

  logic [RW+1:0] rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [VW-1:0] rest_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [VW-1:0] rest_in;
    logic [RW+3:0] sh;
    logic [RW+3:0] trial;
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rest_in = val;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rest_in = rest_r[k-1];
    end
    assign sh    = {rem_in, rest_in[VW-1 -: 2]};
    assign trial = (RW+4)'({root_in, 2'b01});
    always_ff @(posedge clk) begin
      rest_r[k] <= rest_in << 2;
      if (sh >= trial) begin
        rem_r[k]  <= (RW+2)'(sh - trial);
        root_r[k] <= {root_in[RW-2:0], 1'b1};
      end else begin
        rem_r[k]  <= (RW+2)'(sh);
        root_r[k] <= {root_in[RW-2:0], 1'b0};
      end
    end
  end

  assign root = root_r[RW-1];
  assign rem  = rem_r[RW-1][RW:0];

endmodule
`default_nettype wire

### src/acrb_lift.sv
// Maps one pixel position to device coordinates and lifts it onto the unit sphere.
// Depends on acrb_pkg, acrb_div, acrb_sqrt and acrb_dly.
`default_nettype none
module acrb_lift #(
  parameter int COORD_BITS = acrb_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = acrb_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic [COORD_BITS-1:0]         px,
  input  wire logic [COORD_BITS-1:0]         py,
  input  wire logic [acrb_pkg::WIN_W-1:0]    win_w,
  input  wire logic [acrb_pkg::WIN_W-1:0]    win_h,
  output logic signed [FRAC_BITS+1:0]        vx,
  output logic signed [FRAC_BITS+1:0]        vy,
  output logic signed [FRAC_BITS+1:0]        vz
);
  import acrb_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int PW  = F + 2;
  localparam int NW1 = COORD_BITS + F + 2;
  localparam int VW  = 2 * PW;
  localparam int RW  = PW;
  localparam int NW2 = 2 * F + 3;
  localparam int QW2 = F + 2;

  localparam logic signed [NW1:0] ONE_N  = (NW1+1)'(1) <<< F;
  localparam logic signed [NW1:0] SAT_HI = ((NW1+1)'(2) <<< F) - (NW1+1)'(1);
  localparam logic signed [NW1:0] SAT_LO = -((NW1+1)'(2) <<< F);
  localparam logic [VW-1:0]       ONE2   = VW'(1) << (2 * F);

  function automatic logic signed [PW-1:0] sat_pt(input logic signed [NW1:0] v);
    if (v > SAT_HI) begin
      return SAT_HI[PW-1:0];
    end
    if (v < SAT_LO) begin
      return SAT_LO[PW-1:0];
    end
    return v[PW-1:0];
  endfunction

  logic [NW1-1:0] numx, numy, qx, qy;

  assign numx = (NW1'(px) << (F + 1)) + NW1'(win_w >> 1);
  assign numy = (NW1'(py) << (F + 1)) + NW1'(win_h >> 1);

  acrb_div #(.NUM_W(NW1), .DEN_W(WIN_W), .QUO_W(NW1)) u_divx (
    .clk(clk), .num(numx), .den(win_w), .quo(qx)
  );
  acrb_div #(.NUM_W(NW1), .DEN_W(WIN_W), .QUO_W(NW1)) u_divy (
    .clk(clk), .num(numy), .den(win_h), .quo(qy)
  );

  logic signed [NW1:0]  xs, ys;
  logic signed [PW-1:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r, x4_r, y4_r;
  logic signed [VW-1:0] xx_r, yy_r;
  logic [VW-1:0]        s_nxt, v_r;
  logic                 in3_r, in4_r;

  assign xs = signed'({1'b0, qx}) - ONE_N;
  assign ys = ONE_N - signed'({1'b0, qy});

  always_ff @(posedge clk) begin
    x1_r <= sat_pt(xs);
    y1_r <= sat_pt(ys);
    xx_r <= x1_r * x1_r;
    yy_r <= y1_r * y1_r;
    x2_r <= x1_r;
    y2_r <= y1_r;
  end

  assign s_nxt = $unsigned(xx_r) + $unsigned(yy_r);

  always_ff @(posedge clk) begin
    in3_r <= (s_nxt <= ONE2);
    v_r   <= (s_nxt <= ONE2) ? ONE2 - s_nxt : s_nxt;
    x3_r  <= x2_r;
    y3_r  <= y2_r;
  end

  logic [RW-1:0]       root;
  logic [RW:0]         rem;
  logic [2*PW:0]       side3_d;
  logic [RW-1:0]       z4_r;

  acrb_sqrt #(.VW(VW)) u_sqrt (.clk(clk), .val(v_r), .root(root), .rem(rem));

  acrb_dly #(.W(2*PW+1), .DEPTH(RW)) u_dly3 (
    .clk(clk), .d({in3_r, x3_r, y3_r}), .q(side3_d)
  );

  always_ff @(posedge clk) begin
    z4_r  <= root + RW'(rem > {1'b0, root});
    in4_r <= side3_d[2*PW];
    x4_r  <= side3_d[2*PW-1:PW];
    y4_r  <= side3_d[PW-1:0];
  end

  logic [PW-1:0]  ax, ay;
  logic [NW2-1:0] num2x, num2y;
  logic [QW2-1:0] q2x, q2y;

  assign ax    = x4_r[PW-1] ? $unsigned(-x4_r) : $unsigned(x4_r);
  assign ay    = y4_r[PW-1] ? $unsigned(-y4_r) : $unsigned(y4_r);
  assign num2x = (NW2'(ax) << F) + NW2'(z4_r >> 1);
  assign num2y = (NW2'(ay) << F) + NW2'(z4_r >> 1);

  acrb_div #(.NUM_W(NW2), .DEN_W(RW), .QUO_W(QW2)) u_div2x (
    .clk(clk), .num(num2x), .den(z4_r), .quo(q2x)
  );
  acrb_div #(.NUM_W(NW2), .DEN_W(RW), .QUO_W(QW2)) u_div2y (
    .clk(clk), .num(num2y), .den(z4_r), .quo(q2y)
  );

  logic [RW+2*PW:0]     side4_d;
  logic                 in5;
  logic signed [PW-1:0] x5, y5, qxs, qys;
  logic [RW-1:0]        z5;

  acrb_dly #(.W(RW+2*PW+1), .DEPTH(QW2)) u_dly4 (
    .clk(clk), .d({in4_r, z4_r, x4_r, y4_r}), .q(side4_d)
  );

  assign in5 = side4_d[RW+2*PW];
  assign z5  = side4_d[RW+2*PW-1:2*PW];
  assign x5  = side4_d[2*PW-1:PW];
  assign y5  = side4_d[PW-1:0];
  assign qxs = signed'(PW'(q2x));
  assign qys = signed'(PW'(q2y));

  always_ff @(posedge clk) begin
    if (in5) begin
      vx <= x5;
      vy <= y5;
      vz <= signed'(PW'(z5));
    end else begin
      vx <= x5[PW-1] ? -qxs : qxs;
      vy <= y5[PW-1] ? -qys : qys;
      vz <= '0;
    end
  end

endmodule
`default_nettype wire

### src/acrb_acos.sv
// Arc cosine of a clamped dot product by a square root and a vectoring rotator.
// Depends on acrb_pkg, acrb_sqrt and acrb_dly.
`default_nettype none
module acrb_acos #(
  parameter int FRAC_BITS = acrb_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic signed [FRAC_BITS+1:0] d,
  output logic            [FRAC_BITS:0]    angle
);
  import acrb_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int PW = F + 2;
  localparam int RW = SQ_W / 2;
  localparam int SH = TAB_FRAC - (F - 1);

  localparam logic signed [2*PW-1:0] ONE2    = (2*PW)'(1) <<< (2 * F);
  localparam ang_t                   QUARTER = atan_entry(0);
  localparam logic [ANG_W-1:0]       HALF    = ANG_W'(1) << (SH - 1);
  localparam logic [ANG_W-1:0]       PIMAX   = ((ANG_W'(QUARTER) << 2) + HALF) >> SH;

  logic signed [2*PW-1:0] dd_r;
  logic signed [PW-1:0]   d0_r, d_dly;
  logic signed [2*PW-1:0] diff;
  logic [SQ_W-1:0]        sq_in;
  logic [RW-1:0]          root;
  logic [RW:0]            rem_unused;

  always_ff @(posedge clk) begin
    dd_r <= d * d;
    d0_r <= d;
  end

  assign diff  = ONE2 - dd_r;
  assign sq_in = SQ_W'($unsigned(diff)) << (2 * ROOT_FRAC - 2 * F);

  acrb_sqrt #(.VW(SQ_W)) u_sqrt (.clk(clk), .val(sq_in), .root(root), .rem(rem_unused));

  acrb_dly #(.W(PW), .DEPTH(RW)) u_dly (.clk(clk), .d(d0_r), .q(d_dly));

  logic signed [XY_W-1:0] sx0, sy0, px_r, py_r;
  ang_t                   pa_r;

  assign sx0 = XY_W'(d_dly) <<< (ROOT_FRAC - F);
  assign sy0 = signed'(XY_W'(root));

  always_ff @(posedge clk) begin
    if (sx0 < 0) begin
      px_r <= sy0;
      py_r <= -sx0;
      pa_r <= QUARTER <<< 1;
    end else begin
      px_r <= sx0;
      py_r <= sy0;
      pa_r <= '0;
    end
  end

  logic signed [XY_W-1:0] cx_r [CORDIC_STEPS];
  logic signed [XY_W-1:0] cy_r [CORDIC_STEPS];
  ang_t                   ca_r [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    localparam ang_t T = atan_entry(i);
    logic signed [XY_W-1:0] x_in, y_in, dx, dy;
    ang_t                   a_in;
    if (i == 0) begin : g_first
      assign x_in = px_r;
      assign y_in = py_r;
      assign a_in = pa_r;
    end else begin : g_next
      assign x_in = cx_r[i-1];
      assign y_in = cy_r[i-1];
      assign a_in = ca_r[i-1];
    end
    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    always_ff @(posedge clk) begin
      if (y_in > 0) begin
        cx_r[i] <= x_in + dx;
        cy_r[i] <= y_in - dy;
        ca_r[i] <= a_in + T;
      end else begin
        cx_r[i] <= x_in - dx;
        cy_r[i] <= y_in + dy;
        ca_r[i] <= a_in - T;
      end
    end
  end

  ang_t             ang;
  logic [ANG_W-1:0] mag, m;

  assign ang = ca_r[CORDIC_STEPS-1];
  assign mag = ang[ANG_W-1] ? $unsigned(-ang) : $unsigned(ang);
  assign m   = (mag + HALF) >> SH;

  always_ff @(posedge clk) begin
    if (ang[ANG_W-1]) begin
      angle <= '0;
    end else if (m > PIMAX) begin
      angle <= PIMAX[F:0];
    end else begin
      angle <= m[F:0];
    end
  end

endmodule
`default_nettype wire

### src/arcball_rotation_from_drag_core.sv
// Arcball rotation core: drag start and end pixels to angle and cross-product axis.
// Depends on acrb_pkg, acrb_lift, acrb_acos and acrb_dly.
// Its pipeline runs through the pipelined dividers, the square roots and the 32-stage rotator.
// Throughput: one request per cycle; busy stays low and results cannot be stalled.
// Reset clears the pipeline valid flags and loads the window registers 1024 and 768.
`default_nettype none
module arcball_rotation_from_drag_core #(
  parameter int COORD_BITS = acrb_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = acrb_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [COORD_BITS-1:0]       in_start_x,
  input  wire logic [COORD_BITS-1:0]       in_start_y,
  input  wire logic [COORD_BITS-1:0]       in_end_x,
  input  wire logic [COORD_BITS-1:0]       in_end_y,
  output logic                             out_valid,
  output logic [FRAC_BITS:0]               out_rot_angle,
  output logic signed [FRAC_BITS+1:0]      out_axis_x,
  output logic signed [FRAC_BITS+1:0]      out_axis_y,
  output logic signed [FRAC_BITS+1:0]      out_axis_z,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire acrb_pkg::cfg_reg_t          cfg_index,
  input  wire logic [acrb_pkg::WIN_W-1:0]  cfg_wdata
);
  import acrb_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int PW   = F + 2;
  localparam int SW   = 2 * PW + 2;
  localparam int LL   = lift_latency(COORD_BITS, F);
  localparam int AL   = acos_latency();
  localparam int TOT  = LL + 3 + AL;
  localparam logic [SW-1:0] ONE_U  = SW'(1) << F;
  localparam logic [SW-1:0] HALF_U = SW'(1) << (F - 1);

  function automatic logic signed [PW-1:0] rnd_sat(input logic signed [SW-1:0] v);
    logic [SW-1:0] mag;
    logic [SW-1:0] m;
    mag = v[SW-1] ? $unsigned(-v) : $unsigned(v);
    m   = (mag + HALF_U) >> F;
    if (m > ONE_U) begin
      m = ONE_U;
    end
    return v[SW-1] ? -signed'(PW'(m)) : signed'(PW'(m));
  endfunction

  logic [WIN_W-1:0] win_w_r, win_h_r, w_eff, h_eff;
  logic [TOT-1:0]   vld_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_w_r <= WIDTH_RST;
      win_h_r <= HEIGHT_RST;
      vld_r   <= '0;
    end else begin
      vld_r <= {vld_r[TOT-2:0], start && !busy};
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIDTH:  win_w_r <= cfg_wdata;
          REG_HEIGHT: win_h_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign w_eff = (win_w_r == '0) ? WIN_W'(1) : win_w_r;
  assign h_eff = (win_h_r == '0) ? WIN_W'(1) : win_h_r;

  logic signed [PW-1:0] ax, ay, az, bx, by, bz;

  acrb_lift #(.COORD_BITS(COORD_BITS), .FRAC_BITS(F)) u_lift_a (
    .clk(clk), .px(in_start_x), .py(in_start_y), .win_w(w_eff), .win_h(h_eff),
    .vx(ax), .vy(ay), .vz(az)
  );
  acrb_lift #(.COORD_BITS(COORD_BITS), .FRAC_BITS(F)) u_lift_b (
    .clk(clk), .px(in_end_x), .py(in_end_y), .win_w(w_eff), .win_h(h_eff),
    .vx(bx), .vy(by), .vz(bz)
  );

  logic signed [2*PW-1:0] pxx_r, pyy_r, pzz_r;
  logic signed [2*PW-1:0] pyz_r, pzy_r, pzx_r, pxz_r, pxy_r, pyx_r;
  logic signed [SW-1:0]   dot_r, crx_r, cry_r, crz_r;
  logic signed [PW-1:0]   d_r, axx_r, axy_r, axz_r;

  always_ff @(posedge clk) begin
    pxx_r <= ax * bx;
    pyy_r <= ay * by;
    pzz_r <= az * bz;
    pyz_r <= ay * bz;
    pzy_r <= az * by;
    pzx_r <= az * bx;
    pxz_r <= ax * bz;
    pxy_r <= ax * by;
    pyx_r <= ay * bx;
    dot_r <= SW'(pxx_r) + SW'(pyy_r) + SW'(pzz_r);
    crx_r <= SW'(pyz_r) - SW'(pzy_r);
    cry_r <= SW'(pzx_r) - SW'(pxz_r);
    crz_r <= SW'(pxy_r) - SW'(pyx_r);
    d_r   <= rnd_sat(dot_r);
    axx_r <= rnd_sat(crx_r);
    axy_r <= rnd_sat(cry_r);
    axz_r <= rnd_sat(crz_r);
  end

  logic [3*PW-1:0] axis_d;

  acrb_acos #(.FRAC_BITS(F)) u_acos (.clk(clk), .d(d_r), .angle(out_rot_angle));

  acrb_dly #(.W(3*PW), .DEPTH(AL)) u_dly_axis (
    .clk(clk), .d({axx_r, axy_r, axz_r}), .q(axis_d)
  );

  assign out_axis_x = axis_d[3*PW-1:2*PW];
  assign out_axis_y = axis_d[2*PW-1:PW];
  assign out_axis_z = axis_d[PW-1:0];
  assign out_valid  = vld_r[TOT-1];

endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking bench for the arcball rotation core: directed corners, window
// register sweeps and random drags, each checked against a built-in predictor.
// Depends on acrb_pkg and arcball_rotation_from_drag_core.
`timescale 1ns / 1ps
module testbench;
  import acrb_pkg::*;

  localparam int  FB        = 14;
  localparam int  LATENCY   = 134;
  localparam longint ONE    = 64'sd1 << FB;
  localparam longint ONE2   = 64'sd1 << (2 * FB);
  localparam int  CYC_LIMIT = 400000;

  typedef struct packed {
    logic [14:0]        angle;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } rotation_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [11:0] in_start_x, in_start_y, in_end_x, in_end_y;
  logic        out_valid;
  logic [14:0] out_rot_angle;
  logic signed [15:0] out_axis_x, out_axis_y, out_axis_z;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_reg_t    cfg_index;
  logic [12:0] cfg_wdata;

  arcball_rotation_from_drag_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .out_valid(out_valid), .out_rot_angle(out_rot_angle),
    .out_axis_x(out_axis_x), .out_axis_y(out_axis_y), .out_axis_z(out_axis_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  rotation_t pending_rotations[$];
  longint    win_w, win_h;
  longint    atan_q40[CORDIC_STEPS];
  int        failures, results_seen, drags_sent, cycles;
  logic      no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint shift_round(longint v, int s);
    longint m;
    m = (mag(v) + (64'sd1 << (s - 1))) >>> s;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint div_rnd(longint a, longint b);
    longint m;
    m = (mag(a) + b / 2) / b;
    return a < 0 ? -m : m;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned root_near(longint unsigned v);
    longint unsigned z;
    z = root_floor(v);
    if (v - z * z > z) z++;
    return z;
  endfunction

  function automatic longint arctan_recip(longint unsigned n);
    longint unsigned p, k;
    longint sum, term;
    p = (64'd1 << TAB_FRAC) / n;
    sum = 0;
    k = 0;
    while (p != 0) begin
      term = longint'(p / (2 * k + 1));
      sum = k[0] ? sum - term : sum + term;
      p = p / (n * n);
      k++;
    end
    return sum;
  endfunction

  function automatic void sphere_point(longint x, longint y, output longint v[3]);
    longint s, len;
    s = x * x + y * y;
    if (s <= ONE2) begin
      v[0] = x; v[1] = y;
      v[2] = longint'(root_near(longint'(ONE2 - s)));
    end else begin
      len = longint'(root_near(s));
      v[0] = div_rnd(x * ONE, len);
      v[1] = div_rnd(y * ONE, len);
      v[2] = 0;
    end
  endfunction

  function automatic longint arc_cos(longint d);
    longint unsigned r;
    longint sy, sx, ang, t, dx, dy, a, pimax;
    r = longint'(ONE2 - d * d) << (60 - 2 * FB);
    sy = longint'(root_floor(r));
    sx = d * (64'sd1 << (30 - FB));
    ang = 0;
    if (sx < 0) begin
      t = sx; sx = sy; sy = -t;
      ang = 2 * atan_q40[0];
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = sy >>> i;
      dy = sx >>> i;
      if (sy > 0) begin
        sx += dx; sy -= dy; ang += atan_q40[i];
      end else begin
        sx -= dx; sy += dy; ang -= atan_q40[i];
      end
    end
    a = shift_round(ang, TAB_FRAC - (FB - 1));
    pimax = shift_round(4 * atan_q40[0], TAB_FRAC - (FB - 1));
    return clip(a, 0, pimax);
  endfunction

  function automatic rotation_t predict_rotation(longint sx, longint sy, longint ex,
                                                 longint ey);
    longint w, h, p[3], q[3], c[3], dot, d, nx, ny;
    rotation_t r;
    w = win_w == 0 ? 1 : win_w;
    h = win_h == 0 ? 1 : win_h;
    nx = clip((sx * 2 * ONE + w / 2) / w - ONE, -2 * ONE, 2 * ONE - 1);
    ny = clip(ONE - (sy * 2 * ONE + h / 2) / h, -2 * ONE, 2 * ONE - 1);
    sphere_point(nx, ny, p);
    nx = clip((ex * 2 * ONE + w / 2) / w - ONE, -2 * ONE, 2 * ONE - 1);
    ny = clip(ONE - (ey * 2 * ONE + h / 2) / h, -2 * ONE, 2 * ONE - 1);
    sphere_point(nx, ny, q);
    dot = p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
    d = clip(shift_round(dot, FB), -ONE, ONE);
    c[0] = p[1] * q[2] - p[2] * q[1];
    c[1] = p[2] * q[0] - p[0] * q[2];
    c[2] = p[0] * q[1] - p[1] * q[0];
    r.angle = 15'(arc_cos(d));
    r.ax = 16'(clip(shift_round(c[0], FB), -ONE, ONE));
    r.ay = 16'(clip(shift_round(c[1], FB), -ONE, ONE));
    r.az = 16'(clip(shift_round(c[2], FB), -ONE, ONE));
    return r;
  endfunction

  task automatic send_drag(int sx, int sy, int ex, int ey, int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_start_x <= 12'(sx);
    in_start_y <= 12'(sy);
    in_end_x <= 12'(ex);
    in_end_y <= 12'(ey);
    do @(posedge clk); while (!(start && !busy));
    pending_rotations.push_back(predict_rotation(sx, sy, ex, ey));
    drags_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_rotations.size() != 0) @(posedge clk);
  endtask

  task automatic write_window(cfg_reg_t idx, int val);
    drain();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 13'(val);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == REG_WIDTH) win_w = val & 13'h1fff;
    else win_h = val & 13'h1fff;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_gap();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  task automatic test_default_window();
    send_drag(512, 384, 512, 384, 0);
    send_drag(0, 0, 4095, 4095, 0);
    send_drag(4095, 0, 0, 4095, 1);
    send_drag(512, 0, 512, 767, 0);
    send_drag(0, 384, 1023, 384, 2);
    send_drag(600, 300, 400, 500, 0);
    send_drag(512, 384, 1000, 384, 0);
    send_drag(2730, 1365, 1365, 2730, 3);
  endtask

  task automatic test_window_extremes();
    write_window(REG_WIDTH, 1);
    write_window(REG_HEIGHT, 1);
    send_drag(0, 0, 1, 1, 0);
    send_drag(4095, 4095, 0, 0, 0);
    write_window(REG_WIDTH, 0);
    write_window(REG_HEIGHT, 0);
    send_drag(0, 0, 0, 0, 0);
    send_drag(0, 4095, 4095, 0, 1);
    write_window(REG_WIDTH, 4096);
    write_window(REG_HEIGHT, 4096);
    send_drag(2048, 2048, 2048, 2048, 0);
    send_drag(0, 2048, 4095, 2048, 0);
    send_drag(2048, 0, 2048, 4095, 0);
    send_drag(4095, 4095, 0, 0, 0);
    send_drag(3448, 2048, 648, 2048, 2);
    write_window(REG_WIDTH, 8191);
    write_window(REG_HEIGHT, 5461);
    send_drag(4095, 2730, 4095, 2731, 0);
    send_drag(0, 0, 4095, 4095, 0);
  endtask

  task automatic test_random_drags();
    int w, h, sx, sy, ex, ey;
    int widths[6] = '{1024, 640, 4096, 3, 1920, 8191};
    int heights[6] = '{768, 480, 4096, 2, 1080, 6};
    for (int phase = 0; phase < 12; phase++) begin
      if (phase < 6) begin
        w = widths[phase]; h = heights[phase];
      end else begin
        w = $urandom_range(1, 8191); h = $urandom_range(1, 8191);
      end
      write_window(REG_WIDTH, w);
      write_window(REG_HEIGHT, h);
      for (int n = 0; n < 95; n++) begin
        if (n % 32 == 0) no_idle = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 9) < 7) begin
          sx = $urandom_range(0, (w > 4096 ? 4096 : w) - 1);
          sy = $urandom_range(0, (h > 4096 ? 4096 : h) - 1);
          ex = $urandom_range(0, (w > 4096 ? 4096 : w) - 1);
          ey = $urandom_range(0, (h > 4096 ? 4096 : h) - 1);
        end else begin
          sx = $urandom_range(0, 4095); sy = $urandom_range(0, 4095);
          ex = $urandom_range(0, 4095); ey = $urandom_range(0, 4095);
        end
        if ($urandom_range(0, 19) == 0) begin
          ex = sx; ey = sy;
        end
        send_drag(sx, sy, ex, ey, pick_gap());
        if (phase == 3 && n == 50) drain();
      end
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    rotation_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_rotations.size() == 0) begin
        $error("result with nothing outstanding");
        failures++;
      end else begin
        want = pending_rotations.pop_front();
        if (out_rot_angle !== want.angle) begin
          $error("rot_angle expected %0d got %0d", want.angle, out_rot_angle);
          failures++;
        end
        if (out_axis_x !== want.ax) begin
          $error("axis_x expected %0d got %0d", want.ax, out_axis_x);
          failures++;
        end
        if (out_axis_y !== want.ay) begin
          $error("axis_y expected %0d got %0d", want.ay, out_axis_y);
          failures++;
        end
        if (out_axis_z !== want.az) begin
          $error("axis_z expected %0d got %0d", want.az, out_axis_z);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    atan_q40[0] = arctan_recip(2) + arctan_recip(3);
    for (int i = 1; i < CORDIC_STEPS; i++) atan_q40[i] = arctan_recip(64'd1 << i);
    failures = 0; results_seen = 0; drags_sent = 0; cycles = 0;
    no_idle = 1'b0;
    win_w = 1024; win_h = 768;
    rst_n = 1'b0; start = 1'b0; cfg_valid = 1'b0;
    cfg_index = REG_WIDTH; cfg_wdata = '0;
    in_start_x = '0; in_start_y = '0; in_end_x = '0; in_end_y = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_default_window();
    test_window_extremes();
    test_random_drags();
    drain();
    repeat (LATENCY + 20) @(posedge clk);
    $display("Sent %0d drag requests over %0d window settings; %0d results checked.",
             drags_sent, 17, results_seen);
    if (failures == 0 && pending_rotations.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### arcball_rotation_from_drag_core.f
src/acrb_pkg.sv
src/acrb_dly.sv
src/acrb_div.sv
src/acrb_sqrt.sv
src/acrb_lift.sv
src/acrb_acos.sv
src/arcball_rotation_from_drag_core.sv
verif/testbench.sv
